### design/tbe_pkg.sv
// ----------------------------------------------------------------------------
// tbe_pkg
// Shared types and constants of the triangular band energy block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbe_pkg;

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_LOW    = 3'd0;
	localparam logic [2:0] REG_CENTER = 3'd1;
	localparam logic [2:0] REG_HIGH   = 3'd2;
	localparam logic [2:0] REG_RISE   = 3'd3;
	localparam logic [2:0] REG_FALL   = 3'd4;
	localparam logic [2:0] REG_LEN    = 3'd5;
	localparam logic [2:0] REG_MODE   = 3'd6;

	localparam logic [2:0] MODE_LIN = 3'd0;
	localparam logic [2:0] MODE_POW = 3'd1;
	localparam logic [2:0] MODE_DB  = 3'd2;
	localparam logic [2:0] MODE_RMS = 3'd3;
	localparam logic [2:0] MODE_STD = 3'd4;

	localparam logic [16:0] W_ONE    = 17'h10000;
	localparam logic [19:0] DIV_LIN  = 20'd15360;
	localparam logic [19:0] DIV_POW  = 20'd921600;
	localparam logic [19:0] DIV_RMS  = 20'd60;
	localparam logic [63:0] ACC_MAX  = '1;
	localparam logic [47:0] OUT_MAX  = '1;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} tbe_div_res_t;

endpackage

`default_nettype wire

### design/tbe_rdiv.sv
// ----------------------------------------------------------------------------
// tbe_rdiv
// Restoring divider, one quotient bit a cycle, result rounded half up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbe_rdiv
	import tbe_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [63:0]  dividend,
	input  wire logic [19:0]  divisor,
	output tbe_div_res_t      res
);

	logic        run_q;
	logic        fin_q;
	logic [6:0]  cnt_q;
	logic [63:0] dvd_q;
	logic [63:0] quo_q;
	logic [19:0] rem_q;
	logic [19:0] dsr_q;
	logic        done_q;
	logic [63:0] res_q;

	logic [20:0] trial;
	logic        fits;
	logic        round_up;

	assign trial    = {rem_q, dvd_q[63]};
	assign fits     = trial >= {1'b0, dsr_q};
	assign round_up = {rem_q, 1'b0} >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				dvd_q <= dividend;
				dsr_q <= divisor;
				rem_q <= '0;
				quo_q <= '0;
			end else if (run_q) begin
				dvd_q <= {dvd_q[62:0], 1'b0};
				quo_q <= {quo_q[62:0], fits};
				rem_q <= fits ? 20'(trial - {1'b0, dsr_q}) : trial[19:0];
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
				res_q  <= quo_q + 64'(round_up);
			end
		end
	end

	assign res.done     = done_q;
	assign res.quotient = res_q;

endmodule

`default_nettype wire

### design/triangular_band_energy.sv
// An in-band bin is held by the shift-add multiplier, which retires one
// multiplier bit a cycle (the weight, or the magnitude and then the weight,
// or the weight and then the scaled product). The last bin adds the finish:
// a division, a square root and then a division, or normalising and
// squaring for the decibel value.
// One request at a time; reset clears the frame state and loads the defaults.
// ----------------------------------------------------------------------------
// triangular_band_energy
// Weights spectrum bins by a triangular window and reduces them per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangular_band_energy
	import tbe_pkg::*;
#(
	parameter int MAX_BINS  = 4096,
	parameter int MAG_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [MAG_WIDTH-1:0] magnitude,
	input  wire logic                 last_bin,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [47:0]               band_value,
	output logic signed [15:0]        db_value,
	output logic                      saturated,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int BCW = $clog2(MAX_BINS + 1);
	localparam int CW  = (BCW > 12) ? BCW : 12;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_ACC, S_FIN, S_SQRT, S_DIV_START, S_DIV_WAIT,
		S_NORM, S_LOG, S_DBMUL, S_DBFIN, S_OUT
	} state_t;

	state_t state_q;

	logic [11:0] low_q, center_q, high_q;
	logic [16:0] rise_q, fall_q;
	logic [12:0] len_q;
	logic [2:0]  mode_q;

	logic [BCW-1:0] bin_cnt_q;
	logic [12:0]    taken_q;
	logic [16:0]    weight_q;
	logic [16:0]    w_mul_q;
	logic [63:0]    acc_q;
	logic [2:0]     md_q;
	logic           last_q;

	logic [63:0] mul_a_q;
	logic [33:0] mul_b_q;
	logic [63:0] prod_q;
	logic        a_ovf_q;
	logic        p_ovf_q;
	logic        pass_q;

	logic [63:0] sq_v_q, sq_r_q, sq_bit_q;
	logic [63:0] nrm_q;
	logic [5:0]  n_q;
	logic [31:0] x_q;
	logic [15:0] frac_q;
	logic [3:0]  log_cnt_q;
	logic signed [47:0] p_q;

	logic [63:0] div_dvd_q;
	logic [19:0] div_dsr_q;
	tbe_div_res_t div_res;

	logic [47:0]        band_res_q;
	logic signed [15:0] db_res_q;
	logic               sat_res_q;

	logic        wr;
	logic        accept;
	logic [2:0]  md;
	logic [CW-1:0] j_ext;
	logic        in_band;
	logic [17:0] w_sum;
	logic [16:0] w_new;
	logic [64:0] mul_sum;
	logic [63:0] term;
	logic [64:0] acc_sum;
	logic [63:0] sq_t;
	logic [63:0] sq_prod;
	logic [32:0] sq_hi;
	logic [21:0] log_l;
	logic signed [23:0] log_d;
	logic signed [47:0] db_t;

	assign pready   = 1'b1;
	assign wr       = psel && penable && pwrite;
	assign in_stall = state_q != S_IDLE;
	assign accept   = in_valid && !in_stall;

	assign md      = (mode_q > MODE_STD) ? MODE_LIN : mode_q;
	assign j_ext   = CW'(bin_cnt_q);
	assign in_band = (j_ext >= CW'(low_q)) && (j_ext <= CW'(high_q)) && (taken_q < len_q);
	assign w_sum   = {1'b0, weight_q} + {1'b0, rise_q};

	always_comb begin
		if (j_ext == CW'(low_q)) begin
			w_new = (center_q <= low_q) ? W_ONE : '0;
		end else if (j_ext < CW'(center_q)) begin
			w_new = (w_sum > {1'b0, W_ONE}) ? W_ONE : w_sum[16:0];
		end else if (j_ext == CW'(center_q)) begin
			w_new = W_ONE;
		end else begin
			w_new = (weight_q > fall_q) ? 17'(weight_q - fall_q) : '0;
		end
	end

	assign mul_sum = {1'b0, prod_q} + {1'b0, mul_a_q};
	assign term    = p_ovf_q ? ACC_MAX : prod_q;
	assign acc_sum = {1'b0, acc_q} + {1'b0, term};
	assign sq_t    = sq_r_q + sq_bit_q;
	assign sq_prod = 64'(x_q) * 64'(x_q);
	assign sq_hi   = sq_prod[63:31];
	assign log_l   = {n_q, frac_q};
	assign log_d   = $signed({2'b00, log_l}) - 24'sd1435690;
	assign db_t    = ((p_q + 48'sd8388608) >>> 24) - 48'sd10240;

	always_comb begin
		case (paddr[4:2])
			REG_LOW:    prdata = 32'(low_q);
			REG_CENTER: prdata = 32'(center_q);
			REG_HIGH:   prdata = 32'(high_q);
			REG_RISE:   prdata = 32'(rise_q);
			REG_FALL:   prdata = 32'(fall_q);
			REG_LEN:    prdata = 32'(len_q);
			REG_MODE:   prdata = 32'(mode_q);
			default:    prdata = '0;
		endcase
	end

	tbe_rdiv u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIV_START),
		.dividend (div_dvd_q),
		.divisor  (div_dsr_q),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			low_q      <= '0;
			center_q   <= '0;
			high_q     <= '0;
			rise_q     <= '0;
			fall_q     <= '0;
			len_q      <= 13'd4096;
			mode_q     <= MODE_LIN;
			bin_cnt_q  <= '0;
			taken_q    <= '0;
			weight_q   <= '0;
			w_mul_q    <= '0;
			acc_q      <= '0;
			md_q       <= MODE_LIN;
			last_q     <= 1'b0;
			mul_a_q    <= '0;
			mul_b_q    <= '0;
			prod_q     <= '0;
			a_ovf_q    <= 1'b0;
			p_ovf_q    <= 1'b0;
			pass_q     <= 1'b0;
			sq_v_q     <= '0;
			sq_r_q     <= '0;
			sq_bit_q   <= '0;
			nrm_q      <= '0;
			n_q        <= '0;
			x_q        <= '0;
			frac_q     <= '0;
			log_cnt_q  <= '0;
			p_q        <= '0;
			div_dvd_q  <= '0;
			div_dsr_q  <= '0;
			band_res_q <= '0;
			db_res_q   <= '0;
			sat_res_q  <= 1'b0;
			out_valid  <= 1'b0;
			band_value <= '0;
			db_value   <= '0;
			saturated  <= 1'b0;
		end else begin
			if (wr) begin
				case (paddr[4:2])
					REG_LOW:    low_q    <= pwdata[11:0];
					REG_CENTER: center_q <= pwdata[11:0];
					REG_HIGH:   high_q   <= pwdata[11:0];
					REG_RISE:   rise_q   <= pwdata[16:0];
					REG_FALL:   fall_q   <= pwdata[16:0];
					REG_LEN:    len_q    <= pwdata[12:0];
					REG_MODE:   mode_q   <= pwdata[2:0];
					default:    ;
				endcase
			end

			if (out_valid && !out_stall && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						md_q   <= md;
						last_q <= last_bin;
						if (bin_cnt_q < BCW'(MAX_BINS)) begin
							bin_cnt_q <= bin_cnt_q + BCW'(1);
						end
						if (in_band) begin
							weight_q <= w_new;
							w_mul_q  <= w_new;
							taken_q  <= taken_q + 13'd1;
							mul_a_q  <= 64'(magnitude);
							mul_b_q  <= (md == MODE_POW || md == MODE_STD) ?
								34'(magnitude) : 34'(w_new);
							pass_q   <= (md == MODE_POW || md == MODE_STD || md == MODE_RMS);
							prod_q   <= '0;
							a_ovf_q  <= 1'b0;
							p_ovf_q  <= 1'b0;
							state_q  <= S_MUL;
						end else begin
							state_q <= last_bin ? S_FIN : S_IDLE;
						end
						// The frame counters restart once the last bin is in.
						if (last_bin) begin
							bin_cnt_q <= '0;
							taken_q   <= '0;
							weight_q  <= '0;
						end
					end
				end

				S_MUL: begin
					if (mul_b_q == '0) begin
						if (pass_q) begin
							pass_q  <= 1'b0;
							prod_q  <= '0;
							a_ovf_q <= 1'b0;
							if (md_q == MODE_RMS) begin
								mul_a_q <= {8'd0, prod_q[63:8]};
								mul_b_q <= prod_q[41:8];
							end else begin
								mul_a_q <= prod_q;
								mul_b_q <= 34'(w_mul_q);
							end
						end else begin
							state_q <= S_ACC;
						end
					end else begin
						if (mul_b_q[0]) begin
							prod_q  <= mul_sum[63:0];
							p_ovf_q <= p_ovf_q || mul_sum[64] || a_ovf_q;
						end
						mul_a_q <= {mul_a_q[62:0], 1'b0};
						a_ovf_q <= a_ovf_q || mul_a_q[63];
						mul_b_q <= {1'b0, mul_b_q[33:1]};
					end
				end

				S_ACC: begin
					acc_q   <= acc_sum[64] ? ACC_MAX : acc_sum[63:0];
					state_q <= last_q ? S_FIN : S_IDLE;
				end

				S_FIN: begin
					band_res_q <= '0;
					db_res_q   <= '0;
					sat_res_q  <= 1'b0;
					case (md_q)
						MODE_DB: begin
							if (acc_q == '0) begin
								db_res_q <= -16'sd25600;
								state_q  <= S_OUT;
							end else begin
								nrm_q   <= acc_q;
								n_q     <= 6'd63;
								state_q <= S_NORM;
							end
						end
						MODE_RMS, MODE_STD: begin
							if (md_q == MODE_STD && len_q == '0) begin
								state_q <= S_OUT;
							end else begin
								sq_v_q   <= acc_q;
								sq_r_q   <= '0;
								sq_bit_q <= 64'h4000_0000_0000_0000;
								state_q  <= S_SQRT;
							end
						end
						MODE_POW: begin
							div_dvd_q <= acc_q;
							div_dsr_q <= DIV_POW;
							state_q   <= S_DIV_START;
						end
						default: begin
							div_dvd_q <= acc_q;
							div_dsr_q <= DIV_LIN;
							state_q   <= S_DIV_START;
						end
					endcase
				end

				S_SQRT: begin
					if (sq_bit_q == '0) begin
						div_dvd_q <= sq_r_q;
						div_dsr_q <= (md_q == MODE_RMS) ? DIV_RMS : 20'(20'(len_q) * DIV_RMS);
						state_q   <= S_DIV_START;
					end else begin
						if (sq_v_q >= sq_t) begin
							sq_v_q <= sq_v_q - sq_t;
							sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
						end else begin
							sq_r_q <= sq_r_q >> 1;
						end
						sq_bit_q <= sq_bit_q >> 2;
					end
				end

				S_DIV_START: begin
					state_q <= S_DIV_WAIT;
				end

				S_DIV_WAIT: begin
					if (div_res.done) begin
						if (acc_q == ACC_MAX || div_res.quotient > 64'(OUT_MAX)) begin
							band_res_q <= OUT_MAX;
							sat_res_q  <= 1'b1;
						end else begin
							band_res_q <= div_res.quotient[47:0];
						end
						state_q <= S_OUT;
					end
				end

				S_NORM: begin
					if (nrm_q[63]) begin
						x_q       <= nrm_q[63:32];
						frac_q    <= '0;
						log_cnt_q <= '0;
						state_q   <= S_LOG;
					end else begin
						nrm_q <= {nrm_q[62:0], 1'b0};
						n_q   <= n_q - 6'd1;
					end
				end

				S_LOG: begin
					// Squaring the mantissa doubles the exponent: an overflow past
					// two yields the next fraction bit.
					frac_q    <= {frac_q[14:0], sq_hi[32]};
					x_q       <= sq_hi[32] ? sq_hi[32:1] : sq_hi[31:0];
					log_cnt_q <= log_cnt_q + 4'd1;
					if (log_cnt_q == 4'd15) begin
						state_q <= S_DBMUL;
					end
				end

				S_DBMUL: begin
					p_q     <= 48'(log_d) * 48'sd394566;
					state_q <= S_DBFIN;
				end

				S_DBFIN: begin
					if (db_t > 48'sd32767) begin
						db_res_q  <= 16'sd32767;
						sat_res_q <= 1'b1;
					end else if (db_t < -48'sd32768) begin
						db_res_q  <= -16'sd32768;
						sat_res_q <= 1'b1;
					end else begin
						db_res_q  <= db_t[15:0];
						sat_res_q <= (acc_q == ACC_MAX);
					end
					state_q <= S_OUT;
				end

				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid  <= 1'b1;
						band_value <= band_res_q;
						db_value   <= db_res_q;
						saturated  <= sat_res_q;
						acc_q      <= '0;
						state_q    <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/tbe_checker.sv
// ----------------------------------------------------------------------------
// tbe_checker
// Port-level checks of the triangular band energy block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbe_checker #(
	parameter int MAG_WIDTH = 16
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic [MAG_WIDTH-1:0] magnitude,
	input wire logic                 last_bin,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [47:0]          band_value,
	input wire logic signed [15:0]   db_value,
	input wire logic                 saturated
);

	// A stalled result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(band_value) &&
		$stable(db_value) && $stable(saturated))
		else $error("stalled result changed");

	// Only one of the two result fields carries a value.
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && band_value != '0 |-> db_value == '0)
		else $error("both result fields non-zero");

	// A saturated result shows a clipped value in one of its fields.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> band_value == 48'hFFFF_FFFF_FFFF ||
		db_value == 16'sh7FFF || db_value == -16'sh8000)
		else $error("saturated flag without clipped value");

	// After the last bin of a frame the block is busy finishing it.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_bin |=> in_stall)
		else $error("ready straight after the last bin");

endmodule

bind triangular_band_energy tbe_checker #(.MAG_WIDTH(MAG_WIDTH)) u_tbe_checker (.*);

`default_nettype wire

### tb/tb_triangular_band_energy.sv
// ----------------------------------------------------------------------------
// tb_triangular_band_energy
// Streams spectrum frames through the band energy block under random
// configurations and random idling on both sides. A predictor in the bench
// computes each frame result, and every result is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangular_band_energy;
	import tbe_pkg::*;

	typedef struct {
		bit [15:0] mag;
		bit        last;
	} bin_req_t;

	typedef struct {
		bit [47:0]        band;
		bit signed [15:0] db;
		bit               sat;
	} band_res_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [15:0]        magnitude;
	logic               last_bin;
	logic               out_valid;
	logic               out_stall;
	logic [47:0]        band_value;
	logic signed [15:0] db_value;
	logic               saturated;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	triangular_band_energy dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.magnitude(magnitude), .last_bin(last_bin),
		.out_valid(out_valid), .out_stall(out_stall),
		.band_value(band_value), .db_value(db_value), .saturated(saturated),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bin_req_t  pending_bins[$];
	band_res_t expected_bands[$];
	int        errors;
	int        bins_sent;
	int        cycle_count;
	int        send_gap;
	int        stall_left;

	// Configuration copy and frame state of the predictor.
	bit [11:0] cfg_low, cfg_center, cfg_high;
	bit [16:0] cfg_rise, cfg_fall;
	bit [12:0] cfg_len;
	bit [2:0]  cfg_mode;
	int unsigned bin_idx, taken, weight;
	bit [63:0] energy_acc;

	function automatic bit [63:0] sat_mul(bit [63:0] a, bit [63:0] b);
		bit [127:0] pr;
		pr = {64'b0, a} * {64'b0, b};
		return (pr[127:64] != 0) ? '1 : pr[63:0];
	endfunction

	function automatic bit [63:0] round_div(bit [63:0] a, bit [63:0] d);
		return a / d + (((a % d) * 2 >= d) ? 64'd1 : 64'd0);
	endfunction

	function automatic bit [63:0] floor_sqrt(bit [63:0] v);
		bit [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Base-two logarithm in Q.16: the fraction comes from squaring the mantissa.
	function automatic longint log2_q16(bit [63:0] a);
		int        n;
		bit [63:0] x;
		bit [15:0] frac;
		n = 63;
		while (!a[n]) n--;
		x = (n >= 31) ? (a >> (n - 31)) : (a << (31 - n));
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			x = (x * x) >> 31;
			frac = frac << 1;
			if (x >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				x = x >> 1;
			end
		end
		return (longint'(n) <<< 16) + longint'(frac);
	endfunction

	function automatic void band_energy_step(bit [15:0] mag, bit last);
		bit [2:0]  md;
		bit [63:0] m, q, term, band;
		int unsigned w;
		longint    d, p, db;
		bit        sat;
		band_res_t res;
		md = (cfg_mode > MODE_STD) ? MODE_LIN : cfg_mode;
		m = 64'(mag);
		if (bin_idx >= cfg_low && bin_idx <= cfg_high && taken < cfg_len) begin
			w = weight;
			if (bin_idx == cfg_low) w = (cfg_center <= cfg_low) ? 65536 : 0;
			else if (bin_idx < cfg_center) begin
				w = w + cfg_rise;
				if (w > 65536) w = 65536;
			end else if (bin_idx == cfg_center) w = 65536;
			else w = (w > cfg_fall) ? w - cfg_fall : 0;
			weight = w;
			if (md == MODE_POW || md == MODE_STD) term = sat_mul(m * m, 64'(w));
			else if (md == MODE_RMS) begin
				q = (m * w) >> 8;
				term = sat_mul(q, q);
			end else term = m * w;
			energy_acc = (energy_acc + term < energy_acc) ? '1 : energy_acc + term;
			taken++;
		end
		if (bin_idx < 4096) bin_idx++;
		if (!last) return;
		band = 0;
		db = 0;
		sat = 0;
		if (md == MODE_DB) begin
			if (energy_acc == 0) db = -25600;
			else begin
				d = log2_q16(energy_acc) - 1435690;
				p = d * 394566 + (64'sd1 <<< 40) + (64'sd1 <<< 23);
				db = (p >>> 24) - 65536 - 10240;
				if (db > 32767) begin
					db = 32767;
					sat = 1;
				end
				if (db < -32768) begin
					db = -32768;
					sat = 1;
				end
			end
			if (energy_acc == '1) sat = 1;
		end else begin
			if (md == MODE_POW) band = round_div(energy_acc, 921600);
			else if (md == MODE_RMS) band = round_div(floor_sqrt(energy_acc), 60);
			else if (md == MODE_STD)
				band = (cfg_len != 0) ?
					round_div(floor_sqrt(energy_acc), 60 * 64'(cfg_len)) : 0;
			else band = round_div(energy_acc, 15360);
			if (energy_acc == '1 || band > 64'hFFFF_FFFF_FFFF) begin
				band = 64'hFFFF_FFFF_FFFF;
				sat = 1;
			end
		end
		res.band = band[47:0];
		res.db = db[15:0];
		res.sat = sat;
		expected_bands = {expected_bands, res};
		bin_idx = 0;
		taken = 0;
		weight = 0;
		energy_acc = 0;
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Driver: one request per item, with a drawn gap after each.
	always @(posedge clk or negedge arst_n) begin
		bin_req_t it;
		bit       busy;
		if (!arst_n) begin
			in_valid <= 0;
			magnitude <= 0;
			last_bin <= 0;
			send_gap = 0;
		end else begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				band_energy_step(magnitude, last_bin);
				busy = 0;
			end
			if (!busy) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 0;
				end else if (pending_bins.size() != 0) begin
					it = pending_bins.pop_front();
					magnitude <= it.mag;
					last_bin <= it.last;
					in_valid <= 1;
					send_gap = $urandom_range(0, 9);
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// Monitor: checks each accepted result and draws the next stall.
	always @(posedge clk or negedge arst_n) begin
		band_res_t e;
		if (!arst_n) begin
			out_stall <= 0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bands.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result band=%h db=%0d sat=%b",
							band_value, db_value, saturated);
				end else begin
					e = expected_bands.pop_front();
					if (band_value !== e.band || db_value !== e.db || saturated !== e.sat) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected band=%h db=%0d sat=%b, got band=%h db=%0d sat=%b",
								e.band, e.db, e.sat, band_value, db_value, saturated);
					end
				end
				stall_left = $urandom_range(0, 9);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 4000000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(bit [2:0] idx, bit [31:0] value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		case (idx)
			REG_LOW:    cfg_low = value[11:0];
			REG_CENTER: cfg_center = value[11:0];
			REG_HIGH:   cfg_high = value[11:0];
			REG_RISE:   cfg_rise = value[16:0];
			REG_FALL:   cfg_fall = value[16:0];
			REG_LEN:    cfg_len = value[12:0];
			REG_MODE:   cfg_mode = value[2:0];
			default:    ;
		endcase
	endtask

	// Bins without a result may still be in the multiplier, so allow the
	// worst case latency after the last result before touching registers.
	task automatic wait_idle();
		while (pending_bins.size() != 0 || in_valid || expected_bands.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_band(int lo, int ce, int hi, int rs, int fs, int len, int md);
		write_reg(REG_LOW, lo);
		write_reg(REG_CENTER, ce);
		write_reg(REG_HIGH, hi);
		write_reg(REG_RISE, rs);
		write_reg(REG_FALL, fs);
		write_reg(REG_LEN, len);
		write_reg(REG_MODE, md);
	endtask

	task automatic queue_frame(int n, bit big);
		bin_req_t it;
		for (int i = 0; i < n; i++) begin
			it.mag = big ? 16'(16'hFFFF - $urandom_range(0, 15)) :
				16'($urandom_range(0, 65535));
			if ($urandom_range(0, 9) == 0) it.mag = 16'($urandom_range(0, 255));
			it.last = (i == n - 1);
			pending_bins = {pending_bins, it};
		end
		bins_sent += n;
	endtask

	initial begin
		bin_req_t it;
		int lo, ce, hi, rs, fs, len, nf;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		errors = 0;
		bins_sent = 0;
		cycle_count = 0;
		cfg_low = 0;
		cfg_center = 0;
		cfg_high = 0;
		cfg_rise = 0;
		cfg_fall = 0;
		cfg_len = 4096;
		cfg_mode = MODE_LIN;
		bin_idx = 0;
		taken = 0;
		weight = 0;
		energy_acc = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: every mode on a three-bin band with extreme magnitudes.
		for (int md = 0; md < 8; md++) begin
			set_band(0, 1, 2, 65536, 65536, 4096, md);
			it.mag = 16'hFFFF; it.last = 0; pending_bins = {pending_bins, it};
			it.mag = (md == MODE_DB) ? 16'h0000 : 16'h8001;
			pending_bins = {pending_bins, it};
			it.mag = 16'h0000; it.last = 1; pending_bins = {pending_bins, it};
			wait_idle();
		end
		// Zero sum in decibel mode.
		set_band(0, 1, 2, 65536, 65536, 4096, MODE_DB);
		it.mag = 0; it.last = 1; pending_bins = {pending_bins, it};
		wait_idle();

		// Random configuration phases, each with a few frames.
		while (bins_sent < 1450) begin
			lo = $urandom_range(0, 20);
			case ($urandom_range(0, 4))
				0: ce = lo - $urandom_range(0, lo);
				1: ce = lo + 30;
				default: ce = lo + $urandom_range(1, 10);
			endcase
			hi = ($urandom_range(0, 7) == 0) ? lo - 1 - $urandom_range(0, 2)
				: ((ce > lo + 12) ? lo + $urandom_range(0, 12) : ce + $urandom_range(0, 10));
			if (hi < 0) hi = 4095;
			rs = (ce > lo) ? 65536 / (ce - lo) : $urandom_range(0, 65536);
			fs = (hi > ce) ? 65536 / (hi - ce) : $urandom_range(0, 65536);
			if ($urandom_range(0, 5) == 0) rs = $urandom_range(0, 65536);
			if ($urandom_range(0, 5) == 0) fs = ($urandom_range(0, 1) != 0) ? 65536 : 0;
			case ($urandom_range(0, 7))
				0: len = 0;
				1: len = 1;
				2: len = 8191;
				3: len = 4096;
				default: len = $urandom_range(1, 40);
			endcase
			set_band(lo, ce, hi, rs, fs, len, $urandom_range(0, 7));
			nf = $urandom_range(2, 5);
			for (int f = 0; f < nf; f++)
				queue_frame($urandom_range(1, 45), $urandom_range(0, 4) == 0);
			wait_idle();
		end

		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
